### rtl/ecmt_pkg.sv
package ecmt_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT    = 2'd0,
		MODE_CONSUME_TT = 2'd1,
		MODE_CONSUME_T = 2'd2,
		MODE_PURGE     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_KEY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LONG_TIMEOUT  = 2'd0,
		REG_SHORT_TIMEOUT = 2'd1,
		REG_LONG_TYPE     = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	localparam int unsigned AddrW = 5;

	localparam logic [62:0] LongTimeoutRst  = 63'd150000000;
	localparam logic [62:0] ShortTimeoutRst = 63'd50000000;

	typedef struct packed {
		logic [7:0]  call_type;
		logic [31:0] thread_id;
		logic [31:0] source_pid;
		logic [31:0] target_pid;
		logic [63:0] routine;
		logic [63:0] request;
		logic [62:0] ctime;
	} entry_t;

endpackage

### rtl/ecmt_ram.sv
module ecmt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/expiring_context_match_table_core.sv
// Channel | direction | handshake             | payload
// input   | in        | in_valid / in_stall   | mode, now, thread_id, call_type, pids, words
// output  | out       | out_valid / out_stall | status, hit_* fields of the removed entry
// config  | in        | APB write, 64-bit     | long_timeout, short_timeout, long_timeout_type
//
// Insert and a rejected consume by thread go from idle straight to the done state.
// Consume and purge sweep the whole table, one entry per cycle, a pace set by the
// single read port of the entry memory.
// Reset empties the table at once through the fill count; the memory needs no clearing.
// One item is in flight at a time; input stalls while it is worked on or while its
// result beat waits on a stalled output.
module expiring_context_match_table_core #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             mode,
	input  logic [62:0]            now,
	input  logic [31:0]            thread_id,
	input  logic [7:0]             call_type,
	input  logic [31:0]            source_pid,
	input  logic [31:0]            target_pid,
	input  logic [63:0]            routine_word,
	input  logic [63:0]            request_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [7:0]             hit_type,
	output logic [31:0]            hit_thread,
	output logic [31:0]            hit_source_pid,
	output logic [31:0]            hit_target_pid,
	output logic [63:0]            hit_routine,
	output logic [63:0]            hit_request,
	output logic [62:0]            hit_time,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ecmt_pkg::AddrW-1:0] paddr,
	input  logic [63:0]            pwdata,
	output logic [63:0]            prdata,
	output logic                   pready
);

	import ecmt_pkg::*;

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [62:0] long_to_q, short_to_q;
	logic [7:0]  long_type_q;
	reg_idx_t    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_to_q   <= LongTimeoutRst;
			short_to_q  <= ShortTimeoutRst;
			long_type_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_LONG_TIMEOUT:  long_to_q   <= pwdata[62:0];
				REG_SHORT_TIMEOUT: short_to_q  <= pwdata[62:0];
				REG_LONG_TYPE:     long_type_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LONG_TIMEOUT:  prdata = {1'b0, long_to_q};
			REG_SHORT_TIMEOUT: prdata = {1'b0, short_to_q};
			REG_LONG_TYPE:     prdata = {56'd0, long_type_q};
			default:           prdata = '0;
		endcase
	end

	// Item registers, fill count and sweep pointers. Stored entries always occupy
	// slots 0 to n-1, oldest first. A sweep reads slot r and writes each kept entry
	// back to slot w, which never passes r, so no read sees a stale slot.
	mode_t       mode_q;
	logic [62:0] now_q;
	logic [31:0] tid_q;
	logic [7:0]  type_q;
	logic [CW-1:0] count_q, rd_ptr_q, wr_ptr_q;
	logic        rd_valid_s1;
	logic        hit_q;

	logic accept;
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	// Entry memory.
	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata, in_entry;

	assign in_entry = '{call_type: call_type, thread_id: thread_id, source_pid: source_pid,
		target_pid: target_pid, routine: routine_word, request: request_word, ctime: now};

	ecmt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Evaluation of the entry read in the previous cycle.
	logic [63:0] age;
	logic [62:0] limit;
	logic        expired, tt_match, t_match, drop, take;

	always_comb begin
		age     = {1'b0, now_q} - {1'b0, ram_rdata.ctime};
		limit   = (ram_rdata.call_type == long_type_q) ? long_to_q : short_to_q;
		expired = !age[63] && (age[62:0] > limit);
		t_match  = ram_rdata.thread_id == tid_q;
		tt_match = t_match && (ram_rdata.call_type == type_q);
		case (mode_q)
			MODE_CONSUME_TT: begin
				take = !hit_q && !expired && tt_match;
				drop = !hit_q && (expired || tt_match);
			end
			MODE_CONSUME_T: begin
				take = !hit_q && t_match;
				drop = take;
			end
			MODE_PURGE: begin
				take = 1'b0;
				drop = expired;
			end
			default: begin
				take = 1'b0;
				drop = 1'b0;
			end
		endcase
	end

	logic ins_ok;
	assign ins_ok = accept && (mode_t'(mode) == MODE_INSERT) && (count_q != CW'(TABLE_DEPTH));

	always_comb begin
		ram_raddr = rd_ptr_q[IW-1:0];
		if (state_q == S_WALK) begin
			ram_we    = rd_valid_s1 && !drop;
			ram_waddr = wr_ptr_q[IW-1:0];
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = ins_ok;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = in_entry;
		end
	end

	// Result register.
	status_t res_status_q;
	entry_t  res_q;
	logic    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			mode_q       <= MODE_INSERT;
			res_status_q <= ST_OK;
			res_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= mode_t'(mode);
						hit_q    <= 1'b0;
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						res_q    <= '0;
						unique case (mode_t'(mode))
							MODE_INSERT: begin
								state_q      <= S_DONE;
								res_status_q <= ins_ok ? ST_OK : ST_FULL;
								if (ins_ok) begin
									count_q <= count_q + CW'(1);
								end
							end
							MODE_CONSUME_T: begin
								if (thread_id == '0) begin
									state_q      <= S_DONE;
									res_status_q <= ST_BAD_KEY;
								end else begin
									state_q      <= S_WALK;
									res_status_q <= ST_NOT_FOUND;
								end
							end
							MODE_CONSUME_TT: begin
								state_q      <= S_WALK;
								res_status_q <= ST_NOT_FOUND;
							end
							default: begin
								state_q      <= S_WALK;
								res_status_q <= ST_OK;
							end
						endcase
					end
				end
				S_WALK: begin
					if (rd_ptr_q != count_q) begin
						rd_ptr_q    <= rd_ptr_q + CW'(1);
						rd_valid_s1 <= 1'b1;
					end else begin
						rd_valid_s1 <= 1'b0;
					end
					if (rd_valid_s1) begin
						if (!drop) begin
							wr_ptr_q <= wr_ptr_q + CW'(1);
						end
						if (take) begin
							hit_q        <= 1'b1;
							res_q        <= ram_rdata;
							res_status_q <= ST_OK;
						end
					end else if (rd_ptr_q == count_q) begin
						count_q <= wr_ptr_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			now_q  <= now;
			tid_q  <= thread_id;
			type_q <= call_type;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_status_q;
	assign hit_type       = res_q.call_type;
	assign hit_thread     = res_q.thread_id;
	assign hit_source_pid = res_q.source_pid;
	assign hit_target_pid = res_q.target_pid;
	assign hit_routine    = res_q.routine;
	assign hit_request    = res_q.request;
	assign hit_time       = res_q.ctime;

endmodule

### rtl/ecmt_checker.sv
module ecmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] hit_thread,
	input logic [63:0] hit_routine,
	input logic [62:0] hit_time
);

	import ecmt_pkg::*;

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// One item at a time: the cycle after an accepted beat the input stalls.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is in flight");

	// Only a successful consume reports entry contents.
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> hit_thread == '0 && hit_routine == '0
			&& hit_time == '0)
		else $error("non-success result carries entry data");

	// A rejected zero key never reports a thread.
	a_bad_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_KEY |-> hit_thread == '0)
		else $error("bad key result carries a thread");

endmodule

bind expiring_context_match_table_core ecmt_checker u_ecmt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.hit_thread  (hit_thread),
	.hit_routine (hit_routine),
	.hit_time    (hit_time)
);
